// ===== rtl/core/cstc_pkg.sv =====
`timescale 1ns / 1ps

package cstc_pkg;

   // Token lengths above this saturate and report as a lexical error.
   localparam int unsigned MAX_TOKEN_LEN = 64;
   // Pending length counts one past the maximum to flag the overrun.
   localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 2);
   localparam int unsigned TLEN_W = 7;
   localparam int unsigned START_W = 32;

   localparam int unsigned DEF_POSITION_WIDTH = 32;
   localparam int unsigned DEF_QUEUE_DEPTH = 4;

   localparam logic [2:0] TOK_KEYWORD    = 3'd0;
   localparam logic [2:0] TOK_IDENTIFIER = 3'd1;
   localparam logic [2:0] TOK_OPERATOR   = 3'd2;
   localparam logic [2:0] TOK_CONSTANT   = 3'd3;
   localparam logic [2:0] TOK_SYMBOL     = 3'd4;
   localparam logic [2:0] TOK_DIRECTIVE  = 3'd5;
   localparam logic [2:0] TOK_STRING     = 3'd6;
   localparam logic [2:0] TOK_ERROR      = 3'd7;

   localparam int unsigned NUM_KW = 10;
   localparam int unsigned KW_MAX_LEN = 6;

   localparam logic [7:0] KW_CHAR [NUM_KW][KW_MAX_LEN] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00},
      '{"d", "o", "u", "b", "l", "e"},
      '{"c", "h", "a", "r", 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
      '{"v", "o", "i", "d", 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd4
   };

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]         token_type;
      logic [START_W-1:0] token_start;
      logic [TLEN_W-1:0]  token_length;
      logic               last_of_run;
   } rsp_type;

   // One queue entry carries every result of one request.
   typedef struct packed {
      logic    has_second;
      rsp_type first_rec;
      rsp_type second_rec;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== rtl/core/c_source_token_classifier_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                          Direction  Moves
// request   req_valid/req_ready/req_data   in         one source byte or end-of-input
// response  rsp_valid/rsp_ready/rsp_data   out        one token: type, start, length
//
// One request is taken per cycle while the front-to-back queue has room.
// Each request yields zero, one or two responses; the back end sends one per
// cycle while rsp_ready is high, so two responses of one request go out in turn.
// Lexer state lives in one register set in the front end, updated per byte.
// Reset is synchronous and clears all control state.
// Stalls on rsp_ready fill the QUEUE_DEPTH-entry queue, then drop req_ready.

module c_source_token_classifier_top
   import cstc_pkg::*;
#(
   parameter int unsigned POSITION_WIDTH = DEF_POSITION_WIDTH,
   parameter int unsigned QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_status_type q_status;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    head;
   logic         second_pending;

   // Front end: classify each byte and push its results as one entry.
   cstc_front #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_entry(push_entry)
   );

   // Queue: decouple byte intake from response delivery.
   cstc_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .q_status  (q_status),
      .head      (head)
   );

   // Back end: serialize each entry into the output register.
   cstc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head          (head),
      .pop           (pop),
      .second_pending(second_pending),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

`ifndef SYNTHESIS
   // A symbol always closes its run and is one byte long.
   a_symbol_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.token_type == TOK_SYMBOL |->
         rsp_data.token_length == TLEN_W'(1) && rsp_data.last_of_run)
      else $error("symbol response with bad length or run flag");

   // Lengths stay within one and the saturation limit.
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_length != '0 &&
                    rsp_data.token_length <= TLEN_W'(MAX_TOKEN_LEN))
      else $error("response length out of range");

   // A half-drained entry stays at the head until its second result leaves.
   a_second_head: assert property (@(posedge clock) disable iff (reset)
      second_pending |-> !q_status.empty && head.has_second)
      else $error("second result pending without a two-result head entry");

   // The first of two results never closes the run.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && second_pending |-> !rsp_data.last_of_run)
      else $error("first of two results marked last of run");
`endif

endmodule

// ===== rtl/core/cstc_front.sv =====
`timescale 1ns / 1ps

module cstc_front
   import cstc_pkg::*;
#(
   parameter int unsigned POSITION_WIDTH = DEF_POSITION_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   input  q_status_type q_status,
   output logic         push,
   output entry_type    push_entry
);

   localparam logic [1:0] MODE_NORMAL    = 2'd0;
   localparam logic [1:0] MODE_STRING    = 2'd1;
   localparam logic [1:0] MODE_DIRECTIVE = 2'd2;

   localparam logic [2:0] ACT_HOLD   = 3'd0;
   localparam logic [2:0] ACT_START  = 3'd1;
   localparam logic [2:0] ACT_APPEND = 3'd2;
   localparam logic [2:0] ACT_CLEAR  = 3'd3;
   localparam logic [2:0] ACT_RESET  = 3'd4;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   function automatic logic f_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic f_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic f_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic f_word(input logic [7:0] b);
      return f_alpha(b) || f_digit(b) || (b == CH_UNDER);
   endfunction

   function automatic logic f_symbol(input logic [7:0] b);
      return b == ";" || b == "," || b == "(" || b == ")" || b == "{" || b == "}" ||
             b == "[" || b == "]";
   endfunction

   function automatic logic f_op(input logic [7:0] b);
      return b == "+" || b == "-" || b == "*" || b == "/" || b == "%" || b == "&" ||
             b == "|" || b == "^" || b == "~" || b == "<" || b == ">" || b == "!" ||
             b == "=";
   endfunction

   // Keywords that still match with byte b at offset p.
   function automatic logic [NUM_KW-1:0] f_kw_match(input logic [7:0] b,
                                                    input logic [LEN_W-1:0] p);
      logic [NUM_KW-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_KW; i++) begin
         if (p < LEN_W'(KW_LEN[i])) begin
            m[i] = (KW_CHAR[i][p[2:0]] == b);
         end
      end
      return m;
   endfunction

   // Build a token record; saturate an over-long token into a lexical error.
   function automatic rsp_type f_rec(input logic [2:0] t,
                                     input logic [POSITION_WIDTH-1:0] start,
                                     input logic [LEN_W-1:0] len);
      rsp_type r;
      r.token_type   = t;
      r.token_start  = START_W'(start);
      r.token_length = TLEN_W'(len);
      r.last_of_run  = 1'b1;
      if (len > LEN_W'(MAX_TOKEN_LEN)) begin
         r.token_type   = TOK_ERROR;
         r.token_length = TLEN_W'(MAX_TOKEN_LEN);
      end
      return r;
   endfunction

   logic [1:0]                mode_ff, mode_in;
   logic [LEN_W-1:0]          plen_ff, plen_in;
   logic [POSITION_WIDTH-1:0] pstart_ff, pstart_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]                first_ff, first_in;
   logic [7:0]                last_ff, last_in;
   logic [NUM_KW-1:0]         hits_ff, hits_in;
   logic                      ident_ff, ident_in;
   logic                      number_ff, number_in;
   logic                      dot_ff, dot_in;

   logic [7:0]        b;
   logic              accept;
   logic [LEN_W-1:0]  len_app;
   logic [NUM_KW-1:0] len_eq;
   logic [2:0]        normal_type;
   logic [2:0]        act;
   logic [1:0]        start_mode;
   logic              emit_pend;
   logic              emit_sym;
   logic [2:0]        pend_type;
   logic [LEN_W-1:0]  pend_len;
   rsp_type           pend_rec;
   rsp_type           sym_rec;

   assign b         = req_data.byte_value;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign len_app   = (plen_ff <= LEN_W'(MAX_TOKEN_LEN)) ? plen_ff + LEN_W'(1) : plen_ff;

   always_comb begin
      for (int i = 0; i < NUM_KW; i++) begin
         len_eq[i] = (plen_ff == LEN_W'(KW_LEN[i]));
      end
   end

   always_comb begin
      if (|(hits_ff & len_eq)) begin
         normal_type = TOK_KEYWORD;
      end else if (f_alpha(first_ff) || first_ff == CH_UNDER) begin
         normal_type = ident_ff ? TOK_IDENTIFIER : TOK_ERROR;
      end else if (f_op(first_ff)) begin
         normal_type = TOK_OPERATOR;
      end else begin
         normal_type = number_ff ? TOK_CONSTANT : TOK_ERROR;
      end
   end

   // Decide what this request emits and how the pending token moves.
   always_comb begin
      act        = ACT_HOLD;
      start_mode = MODE_NORMAL;
      emit_pend  = 1'b0;
      emit_sym   = 1'b0;
      pend_type  = normal_type;
      pend_len   = plen_ff;
      if (req_data.end_of_input) begin
         act = ACT_RESET;
         case (mode_ff)
            MODE_STRING: begin
               emit_pend = 1'b1;
               pend_type = (first_ff == CH_QUOTE && last_ff == CH_QUOTE) ?
                           TOK_STRING : TOK_ERROR;
            end
            MODE_DIRECTIVE: begin
               emit_pend = 1'b1;
               pend_type = TOK_DIRECTIVE;
            end
            default: begin
               emit_pend = (plen_ff != '0);
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_STRING: begin
               act = ACT_APPEND;
               if (b == CH_QUOTE) begin
                  act       = ACT_CLEAR;
                  emit_pend = 1'b1;
                  pend_type = TOK_STRING;
                  pend_len  = len_app;
               end
            end
            MODE_DIRECTIVE: begin
               act = ACT_APPEND;
               if (f_space(b)) begin
                  act       = ACT_CLEAR;
                  emit_pend = 1'b1;
                  pend_type = TOK_DIRECTIVE;
               end
            end
            default: begin
               if (f_word(b) && plen_ff != '0) begin
                  act = ACT_APPEND;
               end else if (f_word(b)) begin
                  act = ACT_START;
               end else begin
                  emit_pend = (plen_ff != '0);
                  if (b == CH_QUOTE) begin
                     act        = ACT_START;
                     start_mode = MODE_STRING;
                  end else if (b == CH_HASH) begin
                     act        = ACT_START;
                     start_mode = MODE_DIRECTIVE;
                  end else if (f_op(b)) begin
                     act = ACT_START;
                  end else begin
                     act      = ACT_CLEAR;
                     emit_sym = f_symbol(b);
                  end
               end
            end
         endcase
      end
   end

   assign pend_rec = f_rec(pend_type, pstart_ff, pend_len);
   assign sym_rec  = f_rec(TOK_SYMBOL, pos_ff, LEN_W'(1));

   always_comb begin
      push_entry            = '0;
      push_entry.first_rec  = emit_pend ? pend_rec : sym_rec;
      push_entry.second_rec = sym_rec;
      push_entry.has_second = emit_pend && emit_sym;
      if (emit_pend && emit_sym) begin
         push_entry.first_rec.last_of_run = 1'b0;
      end
   end

   assign push = accept && (emit_pend || emit_sym);

   always_comb begin
      mode_in   = mode_ff;
      plen_in   = plen_ff;
      pstart_in = pstart_ff;
      first_in  = first_ff;
      last_in   = last_ff;
      hits_in   = hits_ff;
      ident_in  = ident_ff;
      number_in = number_ff;
      dot_in    = dot_ff;
      pos_in    = pos_ff + POSITION_WIDTH'(1);
      case (act)
         ACT_START: begin
            mode_in   = start_mode;
            plen_in   = LEN_W'(1);
            pstart_in = pos_ff;
            first_in  = b;
            last_in   = b;
            hits_in   = f_kw_match(b, '0);
            ident_in  = f_alpha(b) || b == CH_UNDER;
            number_in = (b == CH_DOT) || f_digit(b);
            dot_in    = (b == CH_DOT);
         end
         ACT_APPEND: begin
            plen_in = len_app;
            last_in = b;
            hits_in = hits_ff & f_kw_match(b, plen_ff);
            if (!f_word(b)) begin
               ident_in = 1'b0;
            end
            if (b == CH_DOT) begin
               if (dot_ff) begin
                  number_in = 1'b0;
               end
               dot_in = 1'b1;
            end else if (!f_digit(b)) begin
               number_in = 1'b0;
            end
         end
         ACT_CLEAR: begin
            mode_in = MODE_NORMAL;
            plen_in = '0;
         end
         ACT_RESET: begin
            mode_in   = MODE_NORMAL;
            plen_in   = '0;
            pstart_in = '0;
            pos_in    = '0;
            first_in  = '0;
            last_in   = '0;
            hits_in   = '1;
            ident_in  = 1'b1;
            number_in = 1'b1;
            dot_in    = 1'b0;
         end
         default: begin
            plen_in = plen_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         plen_ff   <= '0;
         pstart_ff <= '0;
         pos_ff    <= '0;
         first_ff  <= '0;
         last_ff   <= '0;
         hits_ff   <= '1;
         ident_ff  <= 1'b1;
         number_ff <= 1'b1;
         dot_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         plen_ff   <= plen_in;
         pstart_ff <= pstart_in;
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         last_ff   <= last_in;
         hits_ff   <= hits_in;
         ident_ff  <= ident_in;
         number_ff <= number_in;
         dot_ff    <= dot_in;
      end
   end

endmodule

// ===== rtl/core/cstc_queue.sv =====
`timescale 1ns / 1ps

module cstc_queue
   import cstc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output q_status_type q_status,
   output entry_type    head
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        entry_ff [QUEUE_DEPTH];
   entry_type        head_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head           = head_ff;

   always_comb begin
      wr_ptr_in = push ? f_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? f_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Register the next head; bypass an entry written into the head slot.
   always_ff @(posedge clock) begin
      if (push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= push_entry;
      end else begin
         head_ff <= entry_ff[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/cstc_back.sv =====
`timescale 1ns / 1ps

module cstc_back
   import cstc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    head,
   output logic         pop,
   output logic         second_pending,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   logic    half_ff, half_in;
   rsp_type data_ff, data_in;
   logic    load;

   assign load = (!valid_ff || rsp_ready) && !q_status.empty;

   // Drain the head entry one result per cycle while the output can take it; pop as its last result loads.
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      half_in  = half_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (half_ff) begin
            data_in = head.second_rec;
            half_in = 1'b0;
            pop     = 1'b1;
         end else begin
            data_in = head.first_rec;
            if (head.has_second) begin
               half_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data       = data_ff;
   assign second_pending = half_ff;

endmodule
